FILE: hw/rtl/brbd_pkg.sv
`default_nettype none

package brbd_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int MAX_DELIM_DEFAULT = 4;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_BYTES  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_LENGTH = 1'd1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_DELIM = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERWRITE = 2'd1;
    localparam logic [1:0] STATUS_SHORT     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_in;
        logic [6:0] read_length;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       data_valid;
        logic       last;
        logic [1:0] status;
        logic [6:0] stored_count;
        logic       full_res;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/brbd_ram.sv
`default_nettype none

module brbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/byte_ring_buffer_delimited_unit.sv
`default_nettype none

// Byte ring buffer with write, block read, delimited read and clear commands.
// A command is taken when start is high and busy is low. Write, clear, a block
// read of zero bytes or of more bytes than held, and a delimited read on fewer
// bytes than the delimiter length give one word in the cycle after the command,
// and writes can be issued every cycle. A block read of n bytes keeps busy
// high until its last word and delivers its n words back to back; each word
// passes the state register, the memory read and the result register. A
// delimited read first scans the held bytes from the oldest one at one byte
// per cycle. When the delimiter ends at byte k it then delivers those k words
// like a block read. When the delimiter is absent the scan covers all c held
// bytes and then gives the not-found word. The byte memory has a single read
// port. Each word is on result for exactly one cycle with strobe high; the
// receiver cannot hold it off.
module byte_ring_buffer_delimited_unit
    import brbd_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEFAULT,
    parameter int MAX_DELIMITER = MAX_DELIM_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire cmd_t                   cmd,
    output logic                        strobe,
    output result_t                     result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = $clog2(MAX_DELIMITER + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] iss_ptr_reg, iss_ptr_next;
    logic [CW-1:0] iss_left_reg, iss_left_next;
    logic [CW-1:0] out_left_reg, out_left_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_num_reg, pend_num_next;
    logic [7:0]    win_reg [MAX_DELIMITER];
    logic [7:0]    win_next [MAX_DELIMITER];
    logic [31:0]   delim_reg;
    logic [2:0]    dlen_reg;
    logic          strobe_reg, strobe_next;
    result_t       res_reg, res_next;

    logic          ram_we;
    logic          ram_re;
    logic [7:0]    rd_data;
    logic [LW-1:0] eff_len;
    logic [7:0]    dvec [MAX_DELIMITER];
    logic [7:0]    win_new [MAX_DELIMITER];
    logic          mism;
    logic          match;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic result_t make_res(input logic [7:0] data, input logic valid,
                                         input logic lst, input logic [1:0] st,
                                         input logic [CW-1:0] cnt);
        result_t r;
        r.data_out     = data;
        r.data_valid   = valid;
        r.last         = lst;
        r.status       = st;
        r.stored_count = 7'(cnt);
        r.full_res     = (cnt == CW'(DEPTH));
        return r;
    endfunction

    brbd_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (cmd.data_in),
        .re    (ram_re),
        .raddr (iss_ptr_reg),
        .rdata (rd_data)
    );

    // delimiter length clamped to 1..MAX_DELIMITER
    always_comb
    begin
        if (dlen_reg == 3'd0)
        begin
            eff_len = LW'(1);
        end
        else if (int'(dlen_reg) > MAX_DELIMITER)
        begin
            eff_len = LW'(MAX_DELIMITER);
        end
        else
        begin
            eff_len = LW'(dlen_reg);
        end
    end

    // window: entry 0 is the newest scanned byte; delimiter byte j sits at
    // entry eff_len-1-j
    always_comb
    begin
        for (int j = 0; j < MAX_DELIMITER; j++)
        begin
            dvec[j] = (j < 4) ? delim_reg[8*(j%4) +: 8] : 8'd0;
        end
        win_new[0] = rd_data;
        for (int m = 1; m < MAX_DELIMITER; m++)
        begin
            win_new[m] = win_reg[m-1];
        end
        mism = 1'b0;
        for (int m = 0; m < MAX_DELIMITER; m++)
        begin
            for (int j = 0; j < MAX_DELIMITER; j++)
            begin
                if ((m + j + 1 == int'(eff_len)) && (win_new[m] != dvec[j]))
                begin
                    mism = 1'b1;
                end
            end
        end
        match = !mism && (int'(pend_num_reg) >= int'(eff_len));
    end

    always_comb
    begin
        state_next    = state_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        cnt_next      = cnt_reg;
        iss_ptr_next  = iss_ptr_reg;
        iss_left_next = iss_left_reg;
        out_left_next = out_left_reg;
        pend_next     = 1'b0;
        pend_num_next = pend_num_reg;
        win_next      = win_reg;
        strobe_next   = 1'b0;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.kind)
                        KIND_WRITE:
                        begin
                            ram_we      = 1'b1;
                            wp_next     = ptr_next(wp_reg);
                            strobe_next = 1'b1;
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                rp_next  = ptr_next(wp_reg);
                                res_next = make_res(8'd0, 1'b0, 1'b1, STATUS_OVERWRITE,
                                                    cnt_reg);
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 1'b1;
                                res_next = make_res(8'd0, 1'b0, 1'b1, STATUS_OK,
                                                    cnt_reg + 1'b1);
                            end
                        end
                        KIND_BLOCK:
                        begin
                            if (cmd.read_length == 7'd0)
                            begin
                                strobe_next = 1'b1;
                                res_next = make_res(8'd0, 1'b0, 1'b1, STATUS_OK, cnt_reg);
                            end
                            else if (cmd.read_length > 7'(cnt_reg))
                            begin
                                strobe_next = 1'b1;
                                res_next = make_res(8'd0, 1'b0, 1'b1, STATUS_SHORT,
                                                    cnt_reg);
                            end
                            else
                            begin
                                state_next    = ST_EMIT;
                                iss_ptr_next  = rp_reg;
                                iss_left_next = CW'(cmd.read_length);
                                out_left_next = CW'(cmd.read_length);
                            end
                        end
                        KIND_DELIM:
                        begin
                            if (int'(cnt_reg) < int'(eff_len))
                            begin
                                strobe_next = 1'b1;
                                res_next = make_res(8'd0, 1'b0, 1'b1, STATUS_NOT_FOUND,
                                                    cnt_reg);
                            end
                            else
                            begin
                                state_next    = ST_SCAN;
                                iss_ptr_next  = rp_reg;
                                iss_left_next = cnt_reg;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            rp_next     = '0;
                            wp_next     = '0;
                            cnt_next    = '0;
                            strobe_next = 1'b1;
                            res_next    = make_res(8'd0, 1'b0, 1'b1, STATUS_OK, '0);
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (iss_left_reg != '0)
                begin
                    ram_re        = 1'b1;
                    iss_ptr_next  = ptr_next(iss_ptr_reg);
                    iss_left_next = iss_left_reg - 1'b1;
                    pend_next     = 1'b1;
                    pend_num_next = cnt_reg - iss_left_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    win_next = win_new;
                    if (match)
                    begin
                        // delimiter end found: hand the byte count over to delivery
                        state_next    = ST_EMIT;
                        iss_ptr_next  = rp_reg;
                        iss_left_next = pend_num_reg;
                        out_left_next = pend_num_reg;
                        pend_next     = 1'b0;
                    end
                    else if (pend_num_reg == cnt_reg)
                    begin
                        state_next  = ST_IDLE;
                        pend_next   = 1'b0;
                        strobe_next = 1'b1;
                        res_next = make_res(8'd0, 1'b0, 1'b1, STATUS_NOT_FOUND, cnt_reg);
                    end
                end
            end
            ST_EMIT:
            begin
                if (iss_left_reg != '0)
                begin
                    ram_re        = 1'b1;
                    iss_ptr_next  = ptr_next(iss_ptr_reg);
                    iss_left_next = iss_left_reg - 1'b1;
                    pend_next     = 1'b1;
                end
                if (pend_reg)
                begin
                    rp_next       = ptr_next(rp_reg);
                    cnt_next      = cnt_reg - 1'b1;
                    out_left_next = out_left_reg - 1'b1;
                    strobe_next   = 1'b1;
                    res_next = make_res(rd_data, 1'b1, out_left_reg == CW'(1), STATUS_OK,
                                        cnt_reg - 1'b1);
                    if (out_left_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rp_reg       <= '0;
            wp_reg       <= '0;
            cnt_reg      <= '0;
            iss_left_reg <= '0;
            out_left_reg <= '0;
            pend_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            delim_reg    <= 32'd10;
            dlen_reg     <= 3'd1;
        end
        else
        begin
            state_reg    <= state_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            cnt_reg      <= cnt_next;
            iss_left_reg <= iss_left_next;
            out_left_reg <= out_left_next;
            pend_reg     <= pend_next;
            strobe_reg   <= strobe_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DELIM_BYTES:  delim_reg <= cfg_data;
                    REG_DELIM_LENGTH: dlen_reg  <= cfg_data[2:0];
                    default:          dlen_reg  <= dlen_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        iss_ptr_reg  <= iss_ptr_next;
        pend_num_reg <= pend_num_next;
        win_reg      <= win_next;
        res_reg      <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/brbd_checker.sv
`default_nettype none

module brbd_checker
    import brbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire cmd_t    cmd,
    input wire logic    strobe,
    input wire result_t result
);

    // write and clear always answer in the very next cycle
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.kind == KIND_WRITE || cmd.kind == KIND_CLEAR))
        |=> (strobe && result.last && !result.data_valid))
        else $error("write/clear word missing");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.full_res == (result.stored_count == 7'(DEPTH))))
        else $error("full flag disagrees with stored count");

    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.data_valid) |-> (result.last && result.data_out == 8'd0))
        else $error("status word malformed");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.data_valid) |-> (result.status == STATUS_OK))
        else $error("data word with bad status");

endmodule

bind byte_ring_buffer_delimited_unit brbd_checker #(
    .DEPTH(DEPTH)
) u_brbd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire
